// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Each macro expands to one labelled concurrent assertion on a rising clock,
// switched off while the active-low reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/hgtm_pkg.sv
// ----------------------------------------------------------------------------
// HDR gamma tone map package
// Field widths, reset constants and the elaboration-time gamma table builder.
// ----------------------------------------------------------------------------
package hgtm_pkg;

  // Widths fixed by the pixel formats.
  localparam int CHAN_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int PROD_W   = 2 * CHAN_W;
  localparam int IN_DATA_W  = 3 * CHAN_W;
  localparam int OUT_DATA_W = 4 * BYTE_W;

  // Default formats: Q4.12 channels and a 4097-entry gamma table.
  localparam int FRAC_BITS_DEF        = 12;
  localparam int GAMMA_INDEX_BITS_DEF = 12;

  // Reset value of the white point reciprocal (1.0 in Q4.12) and the alpha byte.
  localparam logic [CHAN_W-1:0] INV_WP_RESET = 16'd4096;
  localparam logic [BYTE_W-1:0] ALPHA_BYTE   = 8'hFF;

  // Wide unsigned integer used only while the table is built.
  localparam int BIG_W = 192;
  typedef logic [BIG_W-1:0] bignum_t;

  // Gamma table entry: the largest byte k with k = 0 or
  // idx^5 * 510^11 >= (2k-1)^11 * 2^(5*gbits), i.e. round(255 * x^(1/2.2)).
  // Found by a binary search over the byte value, evaluated at elaboration.
  function automatic logic [BYTE_W-1:0] gamma_entry(input logic [31:0] idx,
                                                   input logic [31:0] gbits);
    bignum_t lhs;
    bignum_t rhs;
    logic [8:0] lo;
    logic [8:0] hi;
    logic [8:0] mid;
    lhs = bignum_t'(1);
    for (int n = 0; n < 5; n++) begin
      lhs = lhs * bignum_t'(idx);
    end
    for (int n = 0; n < 11; n++) begin
      lhs = lhs * bignum_t'(510);
    end
    lo = 9'd0;
    hi = 9'd255;
    for (int s = 0; s < 8; s++) begin
      mid = (lo + hi + 9'd1) >> 1;
      rhs = bignum_t'(1);
      for (int n = 0; n < 11; n++) begin
        rhs = rhs * bignum_t'(2 * mid - 1);
      end
      rhs = rhs << (5 * gbits);
      if (lhs >= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 9'd1;
      end
    end
    return lo[BYTE_W-1:0];
  endfunction

endpackage

// File: rtl/core/hgtm_gamma_lane.sv
// ----------------------------------------------------------------------------
// HDR gamma tone map: one channel lane
// Normalises a scaled channel product to a table index and looks up the
// gamma-encoded byte in a constant table with a registered read.
// ----------------------------------------------------------------------------
module hgtm_gamma_lane #(
  parameter int FRAC_BITS        = hgtm_pkg::FRAC_BITS_DEF,
  parameter int GAMMA_INDEX_BITS = hgtm_pkg::GAMMA_INDEX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        load,      // capture a new byte this cycle
  input  logic [hgtm_pkg::PROD_W-1:0] prod,      // channel times reciprocal
  output logic [hgtm_pkg::BYTE_W-1:0] byte_r
);

  import hgtm_pkg::*;

  localparam int ENTRIES = (1 << GAMMA_INDEX_BITS) + 1;
  localparam int IDX_W   = GAMMA_INDEX_BITS + 1;
  localparam int LVL_W   = FRAC_BITS + 1;
  localparam logic [PROD_W-1:0] ONE_FULL = PROD_W'(1) << FRAC_BITS;

  logic [PROD_W-1:0] lvl_full;
  logic [LVL_W-1:0]  level;
  logic [IDX_W-1:0]  idx;
  logic [BYTE_W-1:0] rom [ENTRIES];
  logic [BYTE_W-1:0] byte_nxt;

  // Gamma table contents, fixed at elaboration.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
    localparam logic [BYTE_W-1:0] ENTRY = gamma_entry(g, GAMMA_INDEX_BITS);
    assign rom[g] = ENTRY;
  end

  // Drop the reciprocal's fraction bits and clamp the level to 1.0.
  always_comb begin
    lvl_full = prod >> FRAC_BITS;
    if (lvl_full > ONE_FULL) begin
      level = ONE_FULL[LVL_W-1:0];
    end else begin
      level = lvl_full[LVL_W-1:0];
    end
  end

  // Rescale the level to the table's index resolution.
  if (GAMMA_INDEX_BITS >= FRAC_BITS) begin : g_idx_up
    assign idx = IDX_W'(level) << (GAMMA_INDEX_BITS - FRAC_BITS);
  end else begin : g_idx_down
    assign idx = IDX_W'(level >> (FRAC_BITS - GAMMA_INDEX_BITS));
  end

  assign byte_nxt = rom[idx];

  // Registered table read; this is the lane's result register.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
    end
  end

endmodule

// File: rtl/core/hdr_gamma_tone_map_unit.sv
// ----------------------------------------------------------------------------
// HDR gamma tone map unit
// Maps one linear Q4.12 RGB pixel per word to a gamma 2.2 encoded 8-bit pixel
// with reversed channel order and opaque alpha.
// ----------------------------------------------------------------------------
//  Channel | Direction | Width | Contents (lowest bits first)
//  in_     | slave     | 48    | chan_first, chan_second, chan_third
//  out_    | master    | 32    | out_first, out_second, out_third, out_alpha
//  cfg_    | write     | 16    | inv_white_point
//
//  Three register stages: input, product, table read. An accepted word moves
//  through the product and table read registers to the output, and one word is
//  taken per clock while the output is not stalled.
//  Each stage advances when it is empty or its successor moves, so bubbles
//  close up under a stalled output. Reset clears the stage valid flags and
//  returns inv_white_point to 1.0.
// ----------------------------------------------------------------------------
module hdr_gamma_tone_map_unit #(
  parameter int FRAC_BITS        = hgtm_pkg::FRAC_BITS_DEF,
  parameter int GAMMA_INDEX_BITS = hgtm_pkg::GAMMA_INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input pixel: chan_first [15:0], chan_second [31:16], chan_third [47:32].
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hgtm_pkg::IN_DATA_W-1:0]  in_tdata,
  // Output pixel: out_first [7:0], out_second [15:8], out_third [23:16],
  // out_alpha [31:24].
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hgtm_pkg::OUT_DATA_W-1:0] out_tdata,
  // White point reciprocal, unsigned Q4.12.
  input  logic                            cfg_wr_en,
  input  logic [hgtm_pkg::CHAN_W-1:0]     cfg_wr_data
);

  import hgtm_pkg::*;

  `include "assert_macros.svh"

  logic [CHAN_W-1:0] inv_wp_r;
  logic [CHAN_W-1:0] inv_wp_nxt;
  logic [CHAN_W-1:0] chan_r [3];
  logic [PROD_W-1:0] prod_r [3];
  logic [BYTE_W-1:0] byte_lane [3];
  logic              v1_r, v2_r, v3_r;
  logic              v1_nxt, v2_nxt, v3_nxt;
  logic              in_acc, adv2, adv3;

  // Stage advance conditions, from the output back to the input.
  assign adv3      = v2_r && (!v3_r || out_tready);
  assign adv2      = v1_r && (!v2_r || adv3);
  assign in_tready = !v1_r || adv2;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    v1_nxt = in_acc ? 1'b1 : (adv2 ? 1'b0 : v1_r);
    v2_nxt = adv2 ? 1'b1 : (adv3 ? 1'b0 : v2_r);
    v3_nxt = adv3 ? 1'b1 : (out_tready ? 1'b0 : v3_r);
    inv_wp_nxt = cfg_wr_en ? cfg_wr_data : inv_wp_r;
  end

  // Control state: valid flags and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      inv_wp_r <= INV_WP_RESET;
    end else begin
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
      v3_r     <= v3_nxt;
      inv_wp_r <= inv_wp_nxt;
    end
  end

  // Input register: one word of three channels.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      chan_r[0] <= in_tdata[CHAN_W-1:0];
      chan_r[1] <= in_tdata[2*CHAN_W-1:CHAN_W];
      chan_r[2] <= in_tdata[3*CHAN_W-1:2*CHAN_W];
    end
  end

  // Product register: each channel scaled by the white point reciprocal.
  always_ff @(posedge clk) begin
    if (adv2) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= PROD_W'(chan_r[c]) * PROD_W'(inv_wp_r);
      end
    end
  end

  // One gamma lane per channel; each holds its own byte of the result.
  for (genvar c = 0; c < 3; c++) begin : g_lane
    hgtm_gamma_lane #(
      .FRAC_BITS       (FRAC_BITS),
      .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)
    ) u_lane (
      .clk   (clk),
      .load  (adv3),
      .prod  (prod_r[c]),
      .byte_r(byte_lane[c])
    );
  end

  // Channel order is reversed on the way out; alpha is always opaque.
  assign out_tvalid = v3_r;
  assign out_tdata  = {ALPHA_BYTE, byte_lane[0], byte_lane[1], byte_lane[2]};

  // With every stage holding a word and the output stalled, nothing enters.
  `ASSERT_SAME_CYCLE(a_full_blocks_input, clk, rst_n, v1_r && v2_r && v3_r && !out_tready, !in_tready)
  // A new output word only follows a filled product stage.
  `ASSERT_SAME_CYCLE(a_out_from_product, clk, rst_n, $rose(v3_r), $past(v2_r))
  // A zero reciprocal scales every channel to zero.
  `ASSERT_NEXT_CYCLE(a_zero_reciprocal, clk, rst_n, adv2 && inv_wp_r == '0, prod_r[0] == '0 && prod_r[1] == '0 && prod_r[2] == '0)

endmodule
